// ----- src/cda_pkg.sv -----
// Shared types, widths and calendar helpers for the date arithmetic unit.
package cda_pkg;

  localparam int OP_W   = 2;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 12;
  localparam int CNT_W  = 16;
  localparam int DIFF_W = 17;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 2'd1;
  localparam logic [OP_W-1:0] OP_DIFF = 2'd2;

  localparam int DAYS_COMMON   = 365;
  localparam int DAYS_LEAP     = 366;
  localparam int YEARS_CENTURY = 100;
  localparam int YEARS_CYCLE   = 400;
  localparam int MONTHS        = 12;

  typedef enum logic [2:0] {
    RES_DATE,
    RES_LOW,
    RES_HIGH,
    RES_DIFF,
    RES_BAD
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      ts_init;
    logic      sel_b;
    logic      walk_reset;
    logic      year_add;
    logic      year_sub;
    logic      month_add;
    logic      month_sub;
    logic      add_day;
    logic      apply_count;
    logic      save_a;
    logic      res_write;
    res_kind_t kind;
  } cda_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ya_ok;
    logic            yb_ok;
    logic            ya_below;
    logic            ts_year_go;
    logic            ts_month_go;
    logic            acc_neg;
    logic            acc_high;
    logic            fs_year_go;
    logic            fs_month_go;
  } cda_stat_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (mon) inside
      4'd2: d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  // Elaboration-time only.
  function automatic bit is_leap(input int y);
    return (y % YEARS_CYCLE == 0) || ((y % YEARS_CENTURY != 0) && (y % 4 == 0));
  endfunction

  // Days from first-01-01 to the end of year last.
  function automatic int span_days(input int first, input int last);
    int s;
    s = 0;
    for (int y = first; y <= last; y++) begin
      s += is_leap(y) ? DAYS_LEAP : DAYS_COMMON;
    end
    return s;
  endfunction

endpackage

// ----- src/cda_ctrl.sv -----
// Sequencer for the date unit: walks the datapath through serial conversion.
module cda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cda_pkg::cda_stat_t  stat,
  output cda_pkg::cda_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TS_YEAR,
    S_TS_MONTH,
    S_TS_DAY,
    S_SER_DONE,
    S_APPLY,
    S_CHECK,
    S_FS_YEAR,
    S_FS_MONTH,
    S_RESULT
  } state_t;

  state_t              state, state_next;
  logic                second, second_next;
  cda_pkg::res_kind_t  kind, kind_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    second_next = second;
    kind_next   = kind;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        second_next = 1'b0;
        unique case (stat.op) inside
          cda_pkg::OP_ADD, cda_pkg::OP_SUB: begin
            if (!stat.ya_ok) begin
              kind_next  = stat.ya_below ? cda_pkg::RES_LOW : cda_pkg::RES_HIGH;
              state_next = S_RESULT;
            end else begin
              cmd.ts_init = 1'b1;
              state_next  = S_TS_YEAR;
            end
          end
          cda_pkg::OP_DIFF: begin
            if (!(stat.ya_ok && stat.yb_ok)) begin
              kind_next  = cda_pkg::RES_BAD;
              state_next = S_RESULT;
            end else begin
              cmd.ts_init = 1'b1;
              state_next  = S_TS_YEAR;
            end
          end
          default: begin
            kind_next  = cda_pkg::RES_BAD;
            state_next = S_RESULT;
          end
        endcase
      end
      S_TS_YEAR: begin
        if (stat.ts_year_go) cmd.year_add = 1'b1;
        else state_next = S_TS_MONTH;
      end
      S_TS_MONTH: begin
        if (stat.ts_month_go) cmd.month_add = 1'b1;
        else state_next = S_TS_DAY;
      end
      S_TS_DAY: begin
        cmd.add_day = 1'b1;
        state_next  = S_SER_DONE;
      end
      S_SER_DONE: begin
        if (stat.op == cda_pkg::OP_DIFF) begin
          if (!second) begin
            // hold serial of A, then convert B
            cmd.save_a  = 1'b1;
            cmd.ts_init = 1'b1;
            cmd.sel_b   = 1'b1;
            second_next = 1'b1;
            state_next  = S_TS_YEAR;
          end else begin
            kind_next  = cda_pkg::RES_DIFF;
            state_next = S_RESULT;
          end
        end else begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply_count = 1'b1;
        cmd.walk_reset  = 1'b1;
        state_next      = S_CHECK;
      end
      S_CHECK: begin
        if (stat.acc_neg) begin
          kind_next  = cda_pkg::RES_LOW;
          state_next = S_RESULT;
        end else if (stat.acc_high) begin
          kind_next  = cda_pkg::RES_HIGH;
          state_next = S_RESULT;
        end else begin
          state_next = S_FS_YEAR;
        end
      end
      S_FS_YEAR: begin
        if (stat.fs_year_go) cmd.year_sub = 1'b1;
        else state_next = S_FS_MONTH;
      end
      S_FS_MONTH: begin
        if (stat.fs_month_go) begin
          cmd.month_sub = 1'b1;
        end else begin
          kind_next  = cda_pkg::RES_DATE;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        cmd.kind = kind;
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.res_write = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      second    <= 1'b0;
      kind      <= cda_pkg::RES_BAD;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
      kind   <= kind_next;
      if (cmd.res_write) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- src/cda_dp.sv -----
// Datapath for the date unit: serial accumulator, year/month walker, result register.
module cda_dp #(
  parameter int FIRST_YEAR = 1900,
  parameter int LAST_YEAR  = 2200
) (
  input  logic                          clk,
  input  logic [cda_pkg::OP_W-1:0]      opcode,
  input  logic [cda_pkg::DAY_W-1:0]     day_a,
  input  logic [cda_pkg::MON_W-1:0]     month_a,
  input  logic [cda_pkg::YEAR_W-1:0]    year_a,
  input  logic [cda_pkg::DAY_W-1:0]     day_b,
  input  logic [cda_pkg::MON_W-1:0]     month_b,
  input  logic [cda_pkg::YEAR_W-1:0]    year_b,
  input  logic [cda_pkg::CNT_W-1:0]     day_count,
  input  cda_pkg::cda_cmd_t             cmd,
  output cda_pkg::cda_stat_t            stat,
  output logic [cda_pkg::DAY_W-1:0]     day_out,
  output logic [cda_pkg::MON_W-1:0]     month_out,
  output logic [cda_pkg::YEAR_W-1:0]    year_out,
  output logic [cda_pkg::DIFF_W-1:0]    day_difference,
  output logic                          invalid
);

  localparam int YW = ($clog2(LAST_YEAR + 1) > cda_pkg::YEAR_W) ?
                      $clog2(LAST_YEAR + 1) : cda_pkg::YEAR_W;
  localparam int TOTAL    = cda_pkg::span_days(FIRST_YEAR, LAST_YEAR);
  localparam int SER_SPAN = (LAST_YEAR - FIRST_YEAR + 1) * cda_pkg::DAYS_LEAP
                            + (1 << cda_pkg::CNT_W) + (1 << cda_pkg::DAY_W);
  localparam int SW = $clog2(SER_SPAN) + 1;

  localparam logic [YW-1:0] FY = YW'(FIRST_YEAR);
  localparam logic [YW-1:0] LY = YW'(LAST_YEAR);
  localparam logic [6:0]    R100_INIT = 7'(FIRST_YEAR % cda_pkg::YEARS_CENTURY);
  localparam logic [8:0]    R400_INIT = 9'(FIRST_YEAR % cda_pkg::YEARS_CYCLE);
  localparam logic [6:0]    R100_LAST = 7'(cda_pkg::YEARS_CENTURY - 1);
  localparam logic [8:0]    R400_LAST = 9'(cda_pkg::YEARS_CYCLE - 1);
  localparam logic signed [SW-1:0] TOTAL_S = SW'(TOTAL);
  localparam logic [cda_pkg::MON_W-1:0] DEC = cda_pkg::MON_W'(cda_pkg::MONTHS);

  // captured beat
  logic [cda_pkg::OP_W-1:0]   op_q;
  logic [cda_pkg::DAY_W-1:0]  day_a_q, day_b_q;
  logic [cda_pkg::MON_W-1:0]  month_a_q, month_b_q;
  logic [cda_pkg::YEAR_W-1:0] year_a_q, year_b_q;
  logic [cda_pkg::CNT_W-1:0]  cnt_q;

  logic                       use_b;
  logic signed [SW-1:0]       acc, acc_next, sa;
  logic [YW-1:0]              yr;
  logic [6:0]                 r100;
  logic [8:0]                 r400;
  logic [cda_pkg::MON_W-1:0]  mon;

  logic                       leap;
  logic signed [SW-1:0]       ylen, mlen, day_m1, cnt_s, day_plus, dsub, dabs;
  logic [YW-1:0]              ya_w, yb_w, tgt_year;
  logic [cda_pkg::MON_W-1:0]  mraw, tgt_mon;
  logic [cda_pkg::DAY_W-1:0]  day_sel;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= opcode;
      day_a_q   <= day_a;
      month_a_q <= month_a;
      year_a_q  <= year_a;
      day_b_q   <= day_b;
      month_b_q <= month_b;
      year_b_q  <= year_b;
      cnt_q     <= day_count;
    end
  end

  assign leap = (r400 == '0) || ((r100 != '0) && (yr[1:0] == 2'b00));
  assign ylen = leap ? SW'(cda_pkg::DAYS_LEAP) : SW'(cda_pkg::DAYS_COMMON);
  assign mlen = SW'(cda_pkg::month_days(mon, leap));

  assign ya_w     = YW'(year_a_q);
  assign yb_w     = YW'(year_b_q);
  assign tgt_year = use_b ? yb_w : ya_w;
  assign mraw     = use_b ? month_b_q : month_a_q;
  assign day_sel  = use_b ? day_b_q : day_a_q;
  assign day_m1   = SW'(day_sel) - SW'(1);
  assign cnt_s    = SW'(cnt_q);

  always_comb begin
    if (mraw == '0) tgt_mon = cda_pkg::MON_W'(1);
    else if (mraw > DEC) tgt_mon = DEC;
    else tgt_mon = mraw;
  end

  always_comb begin
    acc_next = acc;
    if (cmd.ts_init) acc_next = '0;
    else if (cmd.year_add) acc_next = acc + ylen;
    else if (cmd.year_sub) acc_next = acc - ylen;
    else if (cmd.month_add) acc_next = acc + mlen;
    else if (cmd.month_sub) acc_next = acc - mlen;
    else if (cmd.add_day) acc_next = acc + day_m1;
    else if (cmd.apply_count) acc_next = (op_q == cda_pkg::OP_SUB) ? acc - cnt_s : acc + cnt_s;
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (cmd.ts_init) use_b <= cmd.sel_b;
    if (cmd.save_a) sa <= acc;
    if (cmd.ts_init || cmd.walk_reset) begin
      yr   <= FY;
      r100 <= R100_INIT;
      r400 <= R400_INIT;
      mon  <= cda_pkg::MON_W'(1);
    end else begin
      if (cmd.year_add || cmd.year_sub) begin
        yr   <= yr + YW'(1);
        r100 <= (r100 == R100_LAST) ? '0 : r100 + 7'd1;
        r400 <= (r400 == R400_LAST) ? '0 : r400 + 9'd1;
      end
      if (cmd.month_add || cmd.month_sub) mon <= mon + cda_pkg::MON_W'(1);
    end
  end

  always_comb begin
    stat             = '0;
    stat.op          = op_q;
    stat.ya_ok       = (ya_w >= FY) && (ya_w <= LY);
    stat.yb_ok       = (yb_w >= FY) && (yb_w <= LY);
    stat.ya_below    = (ya_w < FY);
    stat.ts_year_go  = (yr < tgt_year);
    stat.ts_month_go = (mon < tgt_mon);
    stat.acc_neg     = acc[SW-1];
    stat.acc_high    = (acc >= TOTAL_S);
    stat.fs_year_go  = (yr < LY) && (acc >= ylen);
    stat.fs_month_go = (mon < DEC) && (acc >= mlen);
  end

  assign day_plus = acc + SW'(1);
  assign dsub     = sa - acc;
  assign dabs     = dsub[SW-1] ? -dsub : dsub;

  always_ff @(posedge clk) begin
    if (cmd.res_write) begin
      unique case (cmd.kind)
        cda_pkg::RES_DATE: begin
          day_out        <= day_plus[cda_pkg::DAY_W-1:0];
          month_out      <= mon;
          year_out       <= yr[cda_pkg::YEAR_W-1:0];
          day_difference <= '0;
          invalid        <= 1'b0;
        end
        cda_pkg::RES_LOW: begin
          day_out        <= cda_pkg::DAY_W'(1);
          month_out      <= cda_pkg::MON_W'(1);
          year_out       <= FY[cda_pkg::YEAR_W-1:0];
          day_difference <= '0;
          invalid        <= 1'b1;
        end
        cda_pkg::RES_HIGH: begin
          day_out        <= cda_pkg::DAY_W'(31);
          month_out      <= DEC;
          year_out       <= LY[cda_pkg::YEAR_W-1:0];
          day_difference <= '0;
          invalid        <= 1'b1;
        end
        cda_pkg::RES_DIFF: begin
          day_out        <= '0;
          month_out      <= '0;
          year_out       <= '0;
          day_difference <= dabs[cda_pkg::DIFF_W-1:0];
          invalid        <= 1'b0;
        end
        default: begin
          day_out        <= '0;
          month_out      <= '0;
          year_out       <= '0;
          day_difference <= '0;
          invalid        <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- src/calendar_date_arithmetic.sv -----
// Top level of the Gregorian date add/subtract/difference unit.
// Dates are handled as day serials counted from FIRST_YEAR-01-01, built and
// taken apart by a walker that steps one year, then one month, per clock.
// Add or subtract builds the serial of date A by walking its years and months,
// applies the day count, then walks years and months again to take the result
// apart; a result that leaves the range skips the second walk. A difference
// builds the serials of both dates the same way and returns their distance.
// Inputs with a year out of range, and opcode 3, skip the walks and go straight
// to the result. A finished result also waits for the output register to free
// up. One beat is in flight at a time; a finished result sits in the output
// register while the next beat is taken in.
module calendar_date_arithmetic #(
  parameter int FIRST_YEAR = 1900,
  parameter int LAST_YEAR  = 2200
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cda_pkg::OP_W-1:0]      opcode,
  input  logic [cda_pkg::DAY_W-1:0]     day_a,
  input  logic [cda_pkg::MON_W-1:0]     month_a,
  input  logic [cda_pkg::YEAR_W-1:0]    year_a,
  input  logic [cda_pkg::DAY_W-1:0]     day_b,
  input  logic [cda_pkg::MON_W-1:0]     month_b,
  input  logic [cda_pkg::YEAR_W-1:0]    year_b,
  input  logic [cda_pkg::CNT_W-1:0]     day_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cda_pkg::DAY_W-1:0]     day_out,
  output logic [cda_pkg::MON_W-1:0]     month_out,
  output logic [cda_pkg::YEAR_W-1:0]    year_out,
  output logic [cda_pkg::DIFF_W-1:0]    day_difference,
  output logic                          invalid
);

  cda_pkg::cda_cmd_t  cmd;
  cda_pkg::cda_stat_t stat;

  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cda_dp #(
    .FIRST_YEAR (FIRST_YEAR),
    .LAST_YEAR  (LAST_YEAR)
  ) u_dp (
    .clk            (clk),
    .opcode         (opcode),
    .day_a          (day_a),
    .month_a        (month_a),
    .year_a         (year_a),
    .day_b          (day_b),
    .month_b        (month_b),
    .year_b         (year_b),
    .day_count      (day_count),
    .cmd            (cmd),
    .stat           (stat),
    .day_out        (day_out),
    .month_out      (month_out),
    .year_out       (year_out),
    .day_difference (day_difference),
    .invalid        (invalid)
  );

endmodule

// ----- src/cda_checker.sv -----
// Port-level checks for the date unit, bound to the top level.
module cda_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cda_pkg::DAY_W-1:0]     day_out,
  input logic [cda_pkg::MON_W-1:0]     month_out,
  input logic [cda_pkg::YEAR_W-1:0]    year_out,
  input logic [cda_pkg::DIFF_W-1:0]    day_difference,
  input logic                          invalid
);

  // one beat at a time: taking a beat closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a beat was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(day_out) && $stable(month_out)
      && $stable(year_out) && $stable(day_difference) && $stable(invalid))
    else $error("stalled result beat changed");

  a_invalid_no_diff: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> day_difference == '0)
    else $error("invalid result carries a day difference");

  a_diff_no_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && (day_difference != '0) |->
      (day_out == '0) && (month_out == '0) && (year_out == '0) && !invalid)
    else $error("difference result carries a date");

  a_date_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (month_out != '0) |->
      (month_out <= cda_pkg::MON_W'(cda_pkg::MONTHS)) && (day_out != '0))
    else $error("date result out of shape");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (.*);
